// ===== hdl/cht_pkg.sv =====
// Package for the chained hash table: status and mode codes, sequencer states.
// No dependencies.
package cht_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HEAD  = 6'b000010,
    S_READ  = 6'b000100,
    S_CHECK = 6'b001000,
    S_LINK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

endpackage

// ===== hdl/chained_hash_table.sv =====
// Chained hash table top level: bucket heads, node pool memories, free stack
// and the chain-walk sequencer. Depends on cht_pkg.
//
// Usage: drive in_mode, in_key and in_payload and pulse start while busy is
// low; the transaction is taken at that edge and busy rises. Insert takes a
// node from the free stack and links it at the head of bucket key mod
// NUM_BUCKETS. Find and delete walk the chain from its head, node by node
// (node memory read, then the key compare), and act on the first node whose
// key matches; delete unlinks it and pushes it back on the stack.
// When the transaction ends, out_valid is high for exactly one cycle with
// out_status and out_found_payload; busy falls in that same cycle.
// The next start is taken in the cycle out_valid is high. The receiver cannot
// stall; results are not held.
// Reset: all bucket heads empty and the free stack holds every node index;
// node memories need no clearing since only linked nodes are ever read.
module chained_hash_table #(
  parameter int NUM_BUCKETS  = 16,
  parameter int POOL_SIZE    = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_mode,
  input  logic [31:0]             in_key,
  input  logic [PAYLOAD_BITS-1:0] in_payload,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [PAYLOAD_BITS-1:0] out_found_payload
);
  import cht_pkg::*;

  localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int LW = $clog2(POOL_SIZE + 1);
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam logic [LW-1:0] LINK_NULL = LW'(POOL_SIZE);

  // Node pool memories, written and read in clocked blocks.
  logic [LW-1:0]           next_mem [POOL_SIZE];
  logic [31:0]             key_mem  [POOL_SIZE];
  logic [PAYLOAD_BITS-1:0] data_mem [POOL_SIZE];
  logic [IW-1:0]           free_mem [POOL_SIZE];

  logic [LW-1:0]           bucket_head_r [NUM_BUCKETS];
  logic [LW-1:0]           free_count_r, free_count_nxt;
  logic [POOL_SIZE-1:0]    fs_valid_r;

  state_t                  state_r, state_nxt;
  logic [1:0]              mode_r;
  logic [31:0]             key_r;
  logic [PAYLOAD_BITS-1:0] payload_r;
  logic [BW-1:0]           bkt_r;
  logic [LW-1:0]           cur_r, cur_nxt, prev_r, prev_nxt;
  logic [LW-1:0]           rd_next_r;
  logic [31:0]             rd_key_r;
  logic [PAYLOAD_BITS-1:0] rd_data_r;
  logic [IW-1:0]           fs_rd_r;
  logic                    out_valid_r;
  logic [1:0]              out_status_r;
  logic [PAYLOAD_BITS-1:0] out_payload_r;
  logic [31:0]             bkt_full;

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found_payload = out_payload_r;
  assign bkt_full          = in_key % NUM_BUCKETS;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_HEAD;
      S_HEAD: begin
        prev_nxt = LINK_NULL;
        cur_nxt  = bucket_head_r[bkt_r];
        if (mode_r == MODE_INSERT) state_nxt = S_LINK;
        else if (mode_r == MODE_DELETE || mode_r == MODE_FIND) state_nxt = S_READ;
        else state_nxt = S_DONE;
      end
      S_READ:  state_nxt = (cur_r >= LINK_NULL) ? S_DONE : S_CHECK;
      S_CHECK: begin
        if (rd_key_r == key_r) begin
          state_nxt = S_DONE;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = rd_next_r;
          state_nxt = S_READ;
        end
      end
      S_LINK:  state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    free_count_nxt = free_count_r;
    if (state_r == S_LINK && free_count_r != '0) free_count_nxt = free_count_r - 1'b1;
    if (state_r == S_CHECK && rd_key_r == key_r && mode_r == MODE_DELETE &&
        free_count_r < LINK_NULL) free_count_nxt = free_count_r + 1'b1;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_count_r <= LINK_NULL;
      fs_valid_r   <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NUM_BUCKETS; i++) bucket_head_r[i] <= LINK_NULL;
    end else begin
      state_r      <= state_nxt;
      free_count_r <= free_count_nxt;
      out_valid_r  <= (state_r == S_DONE);
      if (state_r == S_LINK && free_count_r != '0)
        bucket_head_r[bkt_r] <= LW'(fs_rd_r);
      if (state_r == S_CHECK && rd_key_r == key_r && mode_r == MODE_DELETE) begin
        if (prev_r >= LINK_NULL) bucket_head_r[bkt_r] <= rd_next_r;
        if (free_count_r < LINK_NULL) fs_valid_r[free_count_r[IW-1:0]] <= 1'b1;
      end
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    if (state_r == S_IDLE && start) begin
      mode_r       <= in_mode;
      key_r        <= in_key;
      payload_r    <= in_payload;
      bkt_r        <= bkt_full[BW-1:0];
      out_status_r <= ST_NOT_FOUND;
      out_payload_r <= '0;
    end
    if (state_r == S_HEAD) begin
      if (fs_valid_r[free_count_r[IW-1:0] - 1'b1])
        fs_rd_r <= free_mem[free_count_r[IW-1:0] - 1'b1];
      else
        fs_rd_r <= free_count_r[IW-1:0] - 1'b1;
    end
    if (state_r == S_LINK) begin
      if (free_count_r == '0) begin
        out_status_r <= ST_FULL;
      end else begin
        out_status_r <= ST_OK;
        next_mem[fs_rd_r] <= cur_r;
        key_mem[fs_rd_r]  <= key_r;
        data_mem[fs_rd_r] <= payload_r;
      end
    end
    if (state_r == S_READ && cur_r < LINK_NULL) begin
      rd_next_r <= next_mem[cur_r[IW-1:0]];
      rd_key_r  <= key_mem[cur_r[IW-1:0]];
      rd_data_r <= data_mem[cur_r[IW-1:0]];
    end
    if (state_r == S_CHECK && rd_key_r == key_r) begin
      out_status_r  <= ST_OK;
      out_payload_r <= rd_data_r;
      if (mode_r == MODE_DELETE) begin
        if (prev_r < LINK_NULL) next_mem[prev_r[IW-1:0]] <= rd_next_r;
        if (free_count_r < LINK_NULL) free_mem[free_count_r[IW-1:0]] <= cur_r[IW-1:0];
      end
    end
  end

`ifndef SYNTHESIS
  // The free count never exceeds the pool size.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= LINK_NULL) else $error("free count out of range");
  // A result strobe always closes a transaction.
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == S_DONE) else $error("stray result strobe");
  // A taken transaction makes the block busy.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");
`endif

endmodule
